/* sv/pe96_pkg.sv */
`default_nettype none

package pe96_pkg;

    // Width of every value that passes through the shared arithmetic unit.
    localparam int VW = 62;

    // Saturation limits and clash constants.
    localparam logic [VW-1:0] CAP62 = {VW{1'b1}};
    localparam logic [46:0] MAX48 = {47{1'b1}};
    localparam logic [47:0] CLASH_R2 = 48'd42949672;
    localparam logic [47:0] CLASH_E = 48'd167772160000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CUTOFF = 2'd0;
    localparam logic [1:0] CFG_GRAD = 2'd1;
    localparam logic [1:0] CFG_SELF = 2'd2;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0]
    {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    // Command from the sequencer to the arithmetic unit.
    typedef struct packed
    {
        logic     go;
        unit_op_t op;
        logic [5:0] sh;
    } unit_req_t;

    // Status from the arithmetic unit to the sequencer.
    typedef struct packed
    {
        logic busy;
        logic done;
    } unit_sts_t;

    // One atom pair request.
    typedef struct packed
    {
        logic signed [23:0] disp_x;
        logic signed [23:0] disp_y;
        logic signed [23:0] disp_z;
        logic [31:0] guest_rsix;
        logic [27:0] guest_rcube;
        logic [15:0] guest_root_eps;
        logic [31:0] host_rsix;
        logic [27:0] host_rcube;
        logic [15:0] host_root_eps;
        logic        end_of_guest;
        logic        last_pair;
    } pair_t;

    // One result.
    typedef struct packed
    {
        logic signed [47:0] pair_energy;
        logic signed [47:0] grad_x;
        logic signed [47:0] grad_y;
        logic signed [47:0] grad_z;
        logic signed [47:0] total_energy;
        logic        clash;
        logic        last;
    } res_t;

    // Sequencer states.
    typedef enum logic [4:0]
    {
        ST_IDLE,
        ST_SQ,
        ST_DECIDE,
        ST_G3H3,
        ST_DIVE,
        ST_GSHS,
        ST_EPS,
        ST_SQR,
        ST_R3,
        ST_SQQ,
        ST_W,
        ST_Y,
        ST_Z,
        ST_REP,
        ST_BASE,
        ST_FA,
        ST_FB,
        ST_GRAD,
        ST_OUT
    } state_t;

    // Clamp a signed value to the signed 48-bit range.
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        lo = -64'sh0000_8000_0000_0000;
        if (v > hi)
        begin
            return hi[47:0];
        end
        else if (v < lo)
        begin
            return lo[47:0];
        end
        return v[47:0];
    endfunction

endpackage

`default_nettype wire

/* sv/pair_energy_9_6_accumulator_top.sv */
`default_nettype none

// 9-6 pair energy accumulator. Each request is one guest/host atom pair; the
// block mixes the atom parameters, adds repulsion and dispersion to running
// sums, updates the guest gradient and returns one result per request. All
// arithmetic runs through one shared unit under a sequencer, so the block
// takes one request at a time. A pair that is skipped or clashes goes from
// the accept state through three squarings, the decision and the output
// state. A full pair is dominated by seven divisions with gradients enabled
// and five without, all bit-serial and ending early when the quotient
// saturates or the divisor is zero, plus thirteen (ten without gradients)
// multiplications and two square roots. A finished result waits in an output
// register, and the next request is taken while it does; the block then
// stalls before presenting its next result until the waiting one is taken.
// Configuration writes are accepted on every cycle.
module pair_energy_9_6_accumulator_top
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pair_valid,
    output logic                   pair_ready,
    input  wire pe96_pkg::pair_t   pair,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output pe96_pkg::res_t         res,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import pe96_pkg::*;

    state_t state_reg, state_next;
    logic   wait_reg, wait_next;
    logic [1:0] k_reg, k_next;
    logic   res_valid_reg, res_valid_next;
    logic [31:0] cutoff_reg, cutoff_next;
    logic   grad_en_reg, grad_en_next;
    logic   self_skip_reg, self_skip_next;
    logic signed [47:0] rep_sum_reg, rep_sum_next;
    logic signed [47:0] disp_sum_reg, disp_sum_next;
    logic signed [47:0] grad_reg [3];
    logic signed [47:0] grad_next [3];
    logic   latched_reg, latched_next;

    pair_t  item_reg, item_next;
    logic [47:0]   r2_reg, r2_next;
    logic [VW-1:0] t_reg, t_next;
    logic [VW-1:0] eps_reg, eps_next;
    logic [24:0]   r_reg, r_next;
    logic [VW-1:0] r3_reg, r3_next;
    logic [24:0]   q_reg, q_next;
    logic [VW-1:0] w_reg, w_next;
    logic [VW-1:0] y_reg, y_next;
    logic [46:0]   rep_reg, rep_next;
    logic [46:0]   base_reg, base_next;
    logic          fneg_reg, fneg_next;
    logic [VW-1:0] fm_reg, fm_next;
    logic signed [47:0] pe_reg, pe_next;
    res_t   res_reg, res_next;

    unit_req_t     u_req;
    unit_sts_t     u_sts;
    logic [VW-1:0] u_a, u_b, u_result;
    logic          op_state;

    logic signed [23:0] dk;
    logic [23:0]   dk_mag;
    logic [47:0]   r06;
    logic [46:0]   rep_new, base_new, disp_new;
    logic [48:0]   tri_base;
    logic [VW:0]   fdiff;
    logic signed [63:0] grad_wide;
    logic          grad_neg;
    logic signed [47:0] total;

    pe96_unit u_unit
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (u_req),
        .a      (u_a),
        .b      (u_b),
        .sts    (u_sts),
        .result (u_result)
    );

    // Displacement component chosen by the loop index, and mixed r0^6.
    always_comb
    begin
        case (k_reg)
            2'd0:    dk = item_reg.disp_x;
            2'd1:    dk = item_reg.disp_y;
            default: dk = item_reg.disp_z;
        endcase
        dk_mag = dk[23] ? 24'(-dk) : dk;
        r06 = {15'd0, {1'b0, item_reg.guest_rsix} + {1'b0, item_reg.host_rsix}} << 15;
    end

    // Operation that each arithmetic state hands to the shared unit.
    always_comb
    begin
        op_state = 1'b1;
        u_req.op = OP_MUL;
        u_req.sh = 6'd0;
        u_a = '0;
        u_b = '0;
        case (state_reg)
            ST_SQ:
            begin
                u_a = VW'(dk_mag);
                u_b = VW'(dk_mag);
            end
            ST_G3H3:
            begin
                u_a = VW'(item_reg.guest_rcube);
                u_b = VW'(item_reg.host_rcube);
            end
            ST_DIVE:
            begin
                u_req.op = OP_DIV;
                u_req.sh = 6'd16;
                u_a = t_reg;
                u_b = VW'({1'b0, item_reg.guest_rsix} + {1'b0, item_reg.host_rsix});
            end
            ST_GSHS:
            begin
                u_a = VW'(item_reg.guest_root_eps);
                u_b = VW'(item_reg.host_root_eps);
            end
            ST_EPS:
            begin
                u_req.sh = 6'd31;
                u_a = eps_reg;
                u_b = t_reg;
            end
            ST_SQR:
            begin
                u_req.op = OP_SQRT;
                u_a = VW'(r2_reg);
            end
            ST_R3:
            begin
                u_req.sh = 6'd16;
                u_a = VW'(r2_reg);
                u_b = VW'(r_reg);
            end
            ST_SQQ:
            begin
                u_req.op = OP_SQRT;
                u_a = VW'(r06);
            end
            ST_W:
            begin
                u_req.op = OP_DIV;
                u_req.sh = 6'd32;
                u_a = (k_reg == 2'd0) ? VW'(r06) : w_reg;
                u_b = VW'(r2_reg);
            end
            ST_Y:
            begin
                u_req.op = OP_DIV;
                u_req.sh = 6'd32;
                u_a = VW'({q_reg, 16'd0});
                u_b = r3_reg;
            end
            ST_Z:
            begin
                u_req.sh = 6'd32;
                u_a = w_reg;
                u_b = y_reg;
            end
            ST_REP:
            begin
                u_req.sh = 6'd39;
                u_a = eps_reg;
                u_b = y_reg;
            end
            ST_BASE:
            begin
                u_req.sh = 6'd40;
                u_a = eps_reg;
                u_b = w_reg;
            end
            ST_FA:
            begin
                u_req.op = OP_DIV;
                u_req.sh = 6'd32;
                u_a = VW'({base_reg, 4'd0}) + VW'({base_reg, 1'b0});
                u_b = VW'(r2_reg);
            end
            ST_FB:
            begin
                u_req.op = OP_DIV;
                u_req.sh = 6'd32;
                u_a = VW'({rep_reg, 3'd0}) + VW'(rep_reg);
                u_b = VW'(r2_reg);
            end
            ST_GRAD:
            begin
                u_req.sh = 6'd16;
                u_a = fm_reg;
                u_b = VW'(dk_mag);
            end
            default:
            begin
                op_state = 1'b0;
            end
        endcase
        u_req.go = op_state && !wait_reg;
    end

    // Energy terms and gradient step from the unit result.
    always_comb
    begin
        rep_new = (u_result > VW'(MAX48)) ? MAX48 : u_result[46:0];
        base_new = (u_result > VW'(MAX48)) ? MAX48 : u_result[46:0];
        tri_base = {base_new, 1'b0} + {2'b00, base_new};
        disp_new = (tri_base > {2'b00, MAX48}) ? MAX48 : tri_base[46:0];
        fdiff = {1'b0, t_reg} - {1'b0, u_result};
        grad_neg = fneg_reg != dk[23];
        grad_wide = {{16{grad_reg[k_reg][47]}}, grad_reg[k_reg]};
        total = latched_reg ? rep_sum_reg
                            : sat48({{16{rep_sum_reg[47]}}, rep_sum_reg}
                                    - {{16{disp_sum_reg[47]}}, disp_sum_reg});
    end

    // Sequencer, accumulators and configuration.
    always_comb
    begin
        state_next = state_reg;
        wait_next = wait_reg;
        k_next = k_reg;
        res_valid_next = res_valid_reg;
        cutoff_next = cutoff_reg;
        grad_en_next = grad_en_reg;
        self_skip_next = self_skip_reg;
        rep_sum_next = rep_sum_reg;
        disp_sum_next = disp_sum_reg;
        grad_next = grad_reg;
        latched_next = latched_reg;
        item_next = item_reg;
        r2_next = r2_reg;
        t_next = t_reg;
        eps_next = eps_reg;
        r_next = r_reg;
        r3_next = r3_reg;
        q_next = q_reg;
        w_next = w_reg;
        y_next = y_reg;
        rep_next = rep_reg;
        base_next = base_reg;
        fneg_next = fneg_reg;
        fm_next = fm_reg;
        pe_next = pe_reg;
        res_next = res_reg;

        // Configuration writes.
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CUTOFF: cutoff_next = cfg_data;
                CFG_GRAD:   grad_en_next = cfg_data[0];
                CFG_SELF:   self_skip_next = cfg_data[0];
                default:
                begin
                end
            endcase
        end

        // The result register empties when the consumer takes it.
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (u_req.go)
        begin
            wait_next = 1'b1;
        end
        if (u_sts.done)
        begin
            wait_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pair_valid)
                begin
                    item_next = pair;
                    r2_next = '0;
                    k_next = 2'd0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (u_sts.done)
                begin
                    r2_next = r2_reg + u_result[47:0];
                    if (k_reg == 2'd2)
                    begin
                        k_next = 2'd0;
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_DECIDE:
            begin
                pe_next = '0;
                state_next = ST_OUT;
                if (!latched_reg && !self_skip_reg && r2_reg <= {cutoff_reg, 16'd0})
                begin
                    if (r2_reg <= CLASH_R2)
                    begin
                        latched_next = 1'b1;
                        rep_sum_next = sat48({{16{rep_sum_reg[47]}}, rep_sum_reg}
                                             + {16'd0, CLASH_E});
                        pe_next = CLASH_E;
                    end
                    else
                    begin
                        state_next = ST_G3H3;
                    end
                end
            end
            ST_G3H3:
            begin
                if (u_sts.done)
                begin
                    t_next = u_result;
                    state_next = ST_DIVE;
                end
            end
            ST_DIVE:
            begin
                if (u_sts.done)
                begin
                    t_next = u_result;
                    state_next = ST_GSHS;
                end
            end
            ST_GSHS:
            begin
                if (u_sts.done)
                begin
                    eps_next = u_result;
                    state_next = ST_EPS;
                end
            end
            ST_EPS:
            begin
                if (u_sts.done)
                begin
                    eps_next = u_result;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (u_sts.done)
                begin
                    r_next = u_result[24:0];
                    state_next = ST_R3;
                end
            end
            ST_R3:
            begin
                if (u_sts.done)
                begin
                    r3_next = u_result;
                    state_next = ST_SQQ;
                end
            end
            ST_SQQ:
            begin
                if (u_sts.done)
                begin
                    q_next = u_result[24:0];
                    k_next = 2'd0;
                    state_next = ST_W;
                end
            end
            ST_W:
            begin
                if (u_sts.done)
                begin
                    w_next = u_result;
                    if (k_reg == 2'd2)
                    begin
                        k_next = 2'd0;
                        state_next = ST_Y;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_Y:
            begin
                if (u_sts.done)
                begin
                    y_next = u_result;
                    state_next = ST_Z;
                end
            end
            ST_Z:
            begin
                if (u_sts.done)
                begin
                    y_next = u_result;
                    state_next = ST_REP;
                end
            end
            ST_REP:
            begin
                if (u_sts.done)
                begin
                    rep_next = rep_new;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                // Both energy terms are known: add them to the sums.
                if (u_sts.done)
                begin
                    base_next = base_new;
                    pe_next = signed'({1'b0, rep_reg}) - signed'({1'b0, disp_new});
                    rep_sum_next = sat48({{16{rep_sum_reg[47]}}, rep_sum_reg}
                                         + {17'd0, rep_reg});
                    disp_sum_next = sat48({{16{disp_sum_reg[47]}}, disp_sum_reg}
                                          + {17'd0, disp_new});
                    state_next = grad_en_reg ? ST_FA : ST_OUT;
                end
            end
            ST_FA:
            begin
                if (u_sts.done)
                begin
                    t_next = u_result;
                    state_next = ST_FB;
                end
            end
            ST_FB:
            begin
                if (u_sts.done)
                begin
                    fneg_next = fdiff[VW];
                    fm_next = fdiff[VW] ? VW'(-fdiff) : fdiff[VW-1:0];
                    k_next = 2'd0;
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD:
            begin
                if (u_sts.done)
                begin
                    grad_next[k_reg] = sat48(grad_neg ? grad_wide - {2'b00, u_result}
                                                      : grad_wide + {2'b00, u_result});
                    if (k_reg == 2'd2)
                    begin
                        k_next = 2'd0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_OUT:
            begin
                // Present the result, then apply the end-of-guest and
                // end-of-run clears.
                if (!res_valid_reg || res_ready)
                begin
                    res_next.pair_energy = pe_reg;
                    res_next.grad_x = grad_reg[0];
                    res_next.grad_y = grad_reg[1];
                    res_next.grad_z = grad_reg[2];
                    res_next.total_energy = total;
                    res_next.clash = latched_reg;
                    res_next.last = item_reg.last_pair;
                    res_valid_next = 1'b1;
                    if (item_reg.end_of_guest || item_reg.last_pair)
                    begin
                        grad_next[0] = '0;
                        grad_next[1] = '0;
                        grad_next[2] = '0;
                    end
                    if (item_reg.last_pair)
                    begin
                        rep_sum_next = '0;
                        disp_sum_next = '0;
                        latched_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg <= 1'b0;
            k_reg <= 2'd0;
            res_valid_reg <= 1'b0;
            cutoff_reg <= 32'd4194304;
            grad_en_reg <= 1'b1;
            self_skip_reg <= 1'b0;
            rep_sum_reg <= '0;
            disp_sum_reg <= '0;
            grad_reg[0] <= '0;
            grad_reg[1] <= '0;
            grad_reg[2] <= '0;
            latched_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
            k_reg <= k_next;
            res_valid_reg <= res_valid_next;
            cutoff_reg <= cutoff_next;
            grad_en_reg <= grad_en_next;
            self_skip_reg <= self_skip_next;
            rep_sum_reg <= rep_sum_next;
            disp_sum_reg <= disp_sum_next;
            grad_reg <= grad_next;
            latched_reg <= latched_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        r2_reg <= r2_next;
        t_reg <= t_next;
        eps_reg <= eps_next;
        r_reg <= r_next;
        r3_reg <= r3_next;
        q_reg <= q_next;
        w_reg <= w_next;
        y_reg <= y_next;
        rep_reg <= rep_next;
        base_reg <= base_next;
        fneg_reg <= fneg_next;
        fm_reg <= fm_next;
        pe_reg <= pe_next;
        res_reg <= res_next;
    end

    assign pair_ready = state_reg == ST_IDLE;
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign cfg_ready = 1'b1;

    // The shared unit is never started while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n) u_req.go |-> !u_sts.busy)
        else $error("arithmetic unit started while busy");

    // A completion only arrives while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n) u_sts.done |-> wait_reg)
        else $error("unexpected arithmetic completion");

    // A latched clash always carries its energy penalty in the sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |-> rep_sum_reg >= signed'(CLASH_E))
        else $error("clash latched without its penalty");

    // The dispersion sum never goes negative.
    assert property (@(posedge clk) disable iff (!rst_n) !disp_sum_reg[47])
        else $error("dispersion sum negative");

endmodule

`default_nettype wire

/* sv/pe96_unit.sv */
`default_nettype none

// Shared iterative arithmetic unit: a 32x32 partial-product multiplier with
// shift and saturation, a one-bit-a-cycle restoring divider and a
// two-bits-a-cycle integer square root.
module pe96_unit
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pe96_pkg::unit_req_t  req,
    input  wire logic [61:0]          a,
    input  wire logic [61:0]          b,
    output pe96_pkg::unit_sts_t       sts,
    output logic [61:0]               result
);
    import pe96_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [6:0] cnt_reg, cnt_next;
    unit_op_t   op_reg, op_next;
    logic [5:0] sh_reg, sh_next;

    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg, b_next;
    logic [127:0]  acc_reg, acc_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] quo_reg, quo_next;
    logic [VW-1:0] result_reg, result_next;

    logic [31:0]   pa, pb;
    logic [63:0]   pp;
    logic [127:0]  pp_sh;
    logic [127:0]  mul_sh;
    logic [VW-1:0] mul_sat;
    logic [VW:0]   rem_sh;
    logic          div_ge;
    logic [VW-1:0] rem_nx;
    logic [VW-1:0] quo_nx;
    logic [63:0]   sq_t;
    logic          sq_ge;
    logic [63:0]   sq_res;

    // Partial product of the current quarter, placed at its weight.
    always_comb
    begin
        pa = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = pa * pb;
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        mul_sh = acc_reg >> sh_reg;
        mul_sat = (|mul_sh[127:VW]) ? CAP62 : mul_sh[VW-1:0];
    end

    // One restoring division step.
    always_comb
    begin
        rem_sh = {rem_reg, acc_reg[127]};
        div_ge = rem_sh >= {1'b0, b_reg[VW-1:0]};
        rem_nx = div_ge ? VW'(rem_sh - {1'b0, b_reg[VW-1:0]}) : rem_sh[VW-1:0];
        quo_nx = {quo_reg[VW-2:0], div_ge};
    end

    // One square root step.
    always_comb
    begin
        sq_t = {2'b00, quo_reg} + b_reg;
        sq_ge = a_reg >= sq_t;
        sq_res = sq_ge ? ({2'b00, quo_reg} >> 1) + b_reg : {2'b00, quo_reg} >> 1;
    end

    // Command decode and iteration control.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        op_next = op_reg;
        sh_next = sh_reg;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        result_next = result_reg;
        if (req.go)
        begin
            busy_next = 1'b1;
            op_next = req.op;
            sh_next = req.sh;
            cnt_next = '0;
            a_next = {2'b00, a};
            b_next = {2'b00, b};
            acc_next = '0;
            rem_next = '0;
            quo_next = '0;
            case (req.op)
                OP_DIV:
                begin
                    acc_next = {66'd0, a} << req.sh;
                    if (b == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        result_next = '0;
                    end
                end
                OP_SQRT:
                begin
                    b_next = 64'd1 << 60;
                end
                default:
                begin
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (cnt_reg == 7'd4)
                    begin
                        result_next = mul_sat;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_reg + pp_sh;
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
                OP_DIV:
                begin
                    if (quo_reg[VW-1])
                    begin
                        result_next = CAP62;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_reg << 1;
                        rem_next = rem_nx;
                        quo_next = quo_nx;
                        cnt_next = cnt_reg + 7'd1;
                        if (cnt_reg == 7'd127)
                        begin
                            result_next = quo_nx;
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
                OP_SQRT:
                begin
                    if (sq_ge)
                    begin
                        a_next = a_reg - sq_t;
                    end
                    quo_next = sq_res[VW-1:0];
                    b_next = b_reg >> 2;
                    if (b_reg == 64'd1)
                    begin
                        result_next = sq_res[VW-1:0];
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            op_reg <= OP_MUL;
            sh_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            op_reg <= op_next;
            sh_reg <= sh_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        result_reg <= result_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* tb/sv/pe96_check.sv */
`default_nettype none

module pe96_check
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pair_valid,
    input  wire logic              pair_ready,
    input  wire pe96_pkg::pair_t   pair,
    input  wire logic              res_valid,
    input  wire logic              res_ready,
    input  wire pe96_pkg::res_t    res,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output int                     errors,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import pe96_pkg::*;

    localparam logic [63:0] SAT62 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint HI48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LO48 = -64'sh0000_8000_0000_0000;
    localparam logic [63:0] CLASH_LIMIT = 64'd42949672;
    localparam longint CLASH_ENERGY = 64'sd167772160000;

    // Model copy of the configuration registers.
    logic [31:0] cutoff_reg;
    logic        grad_on;
    logic        self_mode;

    // Model copy of the accumulated state.
    longint rep_total;
    longint disp_total;
    longint grad_acc [3];
    logic   clash_seen;

    res_t energy_results [$];

    assign outstanding = energy_results.size();

    function automatic logic [63:0] mul_scaled(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return (p > {64'd0, SAT62}) ? SAT62 : p[63:0];
    endfunction

    function automatic logic [63:0] div_scaled(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] n;
        logic [127:0] q;
        if (b == 64'd0)
        begin
            return 64'd0;
        end
        n = {64'd0, a} << sh;
        q = n / {64'd0, b};
        return (q > {64'd0, SAT62}) ? SAT62 : q[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint clamp48(longint v);
        return v > HI48 ? HI48 : (v < LO48 ? LO48 : v);
    endfunction

    function automatic logic [63:0] min48(logic [63:0] v);
        return v > 64'(HI48) ? 64'(HI48) : v;
    endfunction

    // Works out the result of one pair and advances the model state.
    function automatic res_t predict_pair(pair_t p);
        longint      d [3];
        logic [63:0] mag_d [3];
        logic [63:0] r2, s, r06, eps, r, r3, q, w, y, z, rep, base, disp, fm, step;
        longint      pe, f, total;
        res_t        o;
        r2 = 64'd0;
        pe = 0;
        d[0] = longint'(p.disp_x);
        d[1] = longint'(p.disp_y);
        d[2] = longint'(p.disp_z);
        for (int k = 0; k < 3; k++)
        begin
            mag_d[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            r2 = r2 + mag_d[k] * mag_d[k];
        end
        if (!clash_seen && !self_mode && r2 <= ({32'd0, cutoff_reg} << 16))
        begin
            if (r2 <= CLASH_LIMIT)
            begin
                // Too close: latch the clash and charge the fixed penalty.
                clash_seen = 1'b1;
                rep_total = clamp48(rep_total + CLASH_ENERGY);
                pe = CLASH_ENERGY;
            end
            else
            begin
                // Sixth-power mixing, then the 9-6 terms.
                s = {32'd0, p.guest_rsix} + {32'd0, p.host_rsix};
                r06 = s << 15;
                eps = 64'd0;
                if (s != 64'd0)
                begin
                    eps = mul_scaled({32'd0, p.guest_root_eps} * {32'd0, p.host_root_eps},
                        div_scaled({36'd0, p.guest_rcube} * {36'd0, p.host_rcube}, s, 16), 31);
                end
                r = floor_sqrt(r2);
                r3 = mul_scaled(r2, r, 16);
                q = floor_sqrt(r06);
                w = div_scaled(div_scaled(div_scaled(r06, r2, 32), r2, 32), r2, 32);
                y = div_scaled(q << 16, r3, 32);
                z = mul_scaled(w, y, 32);
                rep = min48(mul_scaled(eps, z, 39));
                base = min48(mul_scaled(eps, w, 40));
                disp = min48(3 * base);
                pe = longint'(rep) - longint'(disp);
                rep_total = clamp48(rep_total + longint'(rep));
                disp_total = clamp48(disp_total + longint'(disp));
                if (grad_on)
                begin
                    f = longint'(div_scaled(18 * base, r2, 32))
                        - longint'(div_scaled(9 * rep, r2, 32));
                    fm = f < 0 ? 64'(-f) : 64'(f);
                    for (int k = 0; k < 3; k++)
                    begin
                        step = mul_scaled(fm, mag_d[k], 16);
                        if ((f < 0) != (d[k] < 0))
                        begin
                            grad_acc[k] = clamp48(grad_acc[k] - longint'(step));
                        end
                        else
                        begin
                            grad_acc[k] = clamp48(grad_acc[k] + longint'(step));
                        end
                    end
                end
            end
        end
        total = clash_seen ? rep_total : clamp48(rep_total - disp_total);
        o.pair_energy = pe[47:0];
        o.grad_x = grad_acc[0][47:0];
        o.grad_y = grad_acc[1][47:0];
        o.grad_z = grad_acc[2][47:0];
        o.total_energy = total[47:0];
        o.clash = clash_seen;
        o.last = p.last_pair;
        // End of guest or of the whole run clears the gradient afterwards.
        if (p.end_of_guest || p.last_pair)
        begin
            grad_acc[0] = 0;
            grad_acc[1] = 0;
            grad_acc[2] = 0;
        end
        if (p.last_pair)
        begin
            rep_total = 0;
            disp_total = 0;
            clash_seen = 1'b0;
        end
        return o;
    endfunction

    task automatic compare_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each returned result first, then record the new request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg = 32'd4194304;
            grad_on = 1'b1;
            self_mode = 1'b0;
            rep_total = 0;
            disp_total = 0;
            grad_acc[0] = 0;
            grad_acc[1] = 0;
            grad_acc[2] = 0;
            clash_seen = 1'b0;
            errors = 0;
            energy_results.delete();
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (energy_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h", $time, res);
                    errors++;
                end
                else
                begin
                    res_t want;
                    want = energy_results.pop_front();
                    compare_field("pair_energy", want.pair_energy, res.pair_energy);
                    compare_field("grad_x", want.grad_x, res.grad_x);
                    compare_field("grad_y", want.grad_y, res.grad_y);
                    compare_field("grad_z", want.grad_z, res.grad_z);
                    compare_field("total_energy", want.total_energy, res.total_energy);
                    compare_field("clash", 48'(want.clash), 48'(res.clash));
                    compare_field("last", 48'(want.last), 48'(res.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CUTOFF: cutoff_reg = cfg_data;
                    CFG_GRAD:   grad_on = cfg_data[0];
                    CFG_SELF:   self_mode = cfg_data[0];
                    default:    ;
                endcase
            end
            if (pair_valid && pair_ready)
            begin
                energy_results.push_back(predict_pair(pair));
            end
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pe96_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int ANGSTROM = 65536;

    logic        clk;
    logic        rst_n;
    logic        pair_valid;
    logic        pair_ready;
    pair_t       pair;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          outstanding;

    // Idling on both sides, and requests for a long result hold-off.
    logic idle_on;
    int   hold_requests;
    int   hold_seen;
    int   hold_left;
    int   gap_left;
    int   quiet_cycles;

    pair_energy_9_6_accumulator_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .pair(pair),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    pe96_check check
    (
        .clk(clk),
        .rst_n(rst_n),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .pair(pair),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .outstanding(outstanding)
    );

    always #6 clk = ~clk;

    // Result side: random stalls, plus a long hold-off when asked for.
    always @(negedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            res_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap_left = $urandom_range(0, 9);
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if ((pair_valid && pair_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else if (++quiet_cycles >= STALL_LIMIT)
        begin
            $display("[pair_energy_9_6_accumulator_top] ERROR");
            $finish;
        end
    end

    function automatic logic [23:0] signed_coord(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[23:0];
    endfunction

    function automatic pair_t make_pair(logic [23:0] dx, logic [23:0] dy, logic [23:0] dz,
        logic [31:0] g6, logic [27:0] g3, logic [15:0] gs,
        logic [31:0] h6, logic [27:0] h3, logic [15:0] hs, logic eog, logic lp);
        pair_t p;
        p.disp_x = dx;
        p.disp_y = dy;
        p.disp_z = dz;
        p.guest_rsix = g6;
        p.guest_rcube = g3;
        p.guest_root_eps = gs;
        p.host_rsix = h6;
        p.host_rcube = h3;
        p.host_root_eps = hs;
        p.end_of_guest = eog;
        p.last_pair = lp;
        return p;
    endfunction

    // Pairs well inside the cutoff with plausible atoms, some clashes, far pairs
    // from raw random displacements, and a share of raw random parameters.
    function automatic pair_t random_pair();
        pair_t p;
        int    sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            p.disp_x = signed_coord(80000);
            p.disp_y = signed_coord(80000);
            p.disp_z = signed_coord(80000);
        end
        else if (sel < 46)
        begin
            p.disp_x = signed_coord(3000);
            p.disp_y = signed_coord(3000);
            p.disp_z = signed_coord(3000);
        end
        else
        begin
            p.disp_x = 24'($urandom());
            p.disp_y = 24'($urandom());
            p.disp_z = 24'($urandom());
        end
        sel = $urandom_range(0, 99);
        if (sel < 65)
        begin
            p.guest_rsix = $urandom_range(20000000, 400000000);
            p.host_rsix = $urandom_range(20000000, 400000000);
            p.guest_rcube = 28'($urandom_range(1000000, 8000000));
            p.host_rcube = 28'($urandom_range(1000000, 8000000));
        end
        else if (sel < 70)
        begin
            p.guest_rsix = 32'd0;
            p.host_rsix = 32'd0;
            p.guest_rcube = 28'($urandom());
            p.host_rcube = 28'($urandom());
        end
        else
        begin
            p.guest_rsix = $urandom();
            p.host_rsix = $urandom();
            p.guest_rcube = 28'($urandom());
            p.host_rcube = 28'($urandom());
        end
        p.guest_root_eps = 16'($urandom());
        p.host_root_eps = 16'($urandom());
        p.end_of_guest = $urandom_range(0, 5) == 0;
        p.last_pair = $urandom_range(0, 29) == 0;
        return p;
    endfunction

    task automatic send_pair(pair_t p);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            pair_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        pair_valid = 1'b1;
        pair = p;
        do
        begin
            @(posedge clk);
        end
        while (!pair_ready);
        @(negedge clk);
        pair_valid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drain every expected result, then let any trailing work settle.
    task automatic drain();
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic random_run(int count);
        for (int i = 0; i < count; i++)
        begin
            send_pair(random_pair());
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        res_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CUTOFF;
        cfg_data = '0;
        idle_on = 1'b1;
        hold_requests = 0;
        hold_seen = 0;
        hold_left = 0;
        gap_left = 0;
        quiet_cycles = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pairs under the reset settings.
        send_pair(make_pair(24'd0, 24'd0, 24'd0, 32'd0, 28'd0, 16'd0,
            32'd0, 28'd0, 16'd0, 1'b0, 1'b0));
        send_pair(make_pair(24'd65536, 24'd0, 24'd0, 32'd0, 28'd0, 16'd0,
            32'd0, 28'd0, 16'd0, 1'b0, 1'b1));
        send_pair(make_pair(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'hFFFFFFFF, 28'hFFFFFFF,
            16'hFFFF, 32'hFFFFFFFF, 28'hFFFFFFF, 16'hFFFF, 1'b0, 1'b0));
        send_pair(make_pair(24'd70000, -24'sd40000, 24'd20000, 32'd120000000, 28'd2800000,
            16'd19660, 32'd90000000, 28'd2400000, 16'd30000, 1'b0, 1'b0));
        send_pair(make_pair(24'd6000, 24'd3000, -24'sd2000, 32'hFFFFFFFF, 28'hFFFFFFF,
            16'hFFFF, 32'hFFFFFFFF, 28'hFFFFFFF, 16'hFFFF, 1'b1, 1'b0));
        send_pair(make_pair(-24'sd100000, 24'd10, 24'd0, 32'd1, 28'd1, 16'd1,
            32'd0, 28'd0, 16'd0, 1'b0, 1'b0));
        send_pair(make_pair(24'd4000, 24'd4000, 24'd4000, 32'd200000000, 28'd4000000,
            16'd40000, 32'd200000000, 28'd4000000, 16'd40000, 1'b1, 1'b0));
        send_pair(make_pair(24'd1000, 24'd0, 24'd0, 32'd200000000, 28'd4000000,
            16'd40000, 32'd200000000, 28'd4000000, 16'd40000, 1'b0, 1'b0));
        send_pair(make_pair(24'd90000, 24'd0, 24'd0, 32'd200000000, 28'd4000000,
            16'd40000, 32'd200000000, 28'd4000000, 16'd40000, 1'b0, 1'b0));
        send_pair(make_pair(24'd0, 24'd50000, 24'd0, 32'd200000000, 28'd4000000,
            16'd40000, 32'd200000000, 28'd4000000, 16'd40000, 1'b0, 1'b1));
        send_pair(make_pair(24'd0, 24'd0, 24'd7000, 32'hFFFFFFFF, 28'd0, 16'hFFFF,
            32'hFFFFFFFF, 28'd0, 16'hFFFF, 1'b1, 1'b1));
        send_pair(make_pair(24'd131072, 24'd0, 24'd0, 32'd300000000, 28'd5000000,
            16'd20000, 32'd100000000, 28'd2000000, 16'd50000, 1'b0, 1'b1));

        // Reset settings under random traffic, with a long result hold-off.
        hold_requests++;
        random_run(150);
        drain();

        // Widest cutoff with the gradient off.
        write_reg(CFG_CUTOFF, 32'hFFFFFFFF);
        write_reg(CFG_GRAD, 32'd0);
        random_run(150);
        drain();

        // Zero cutoff: only coincident atoms fall inside it.
        write_reg(CFG_CUTOFF, 32'd0);
        write_reg(CFG_GRAD, 32'd1);
        send_pair(make_pair(24'd0, 24'd0, 24'd0, 32'd5, 28'd5, 16'd5,
            32'd5, 28'd5, 16'd5, 1'b0, 1'b1));
        random_run(150);
        drain();

        // Self mode skips everything.
        write_reg(CFG_CUTOFF, 32'd4194304);
        write_reg(CFG_SELF, 32'd1);
        random_run(120);
        drain();

        // A narrower cutoff with the gradient on, and no idling at the end.
        write_reg(CFG_SELF, 32'd0);
        write_reg(CFG_CUTOFF, 32'd9 * 32'd65536);
        random_run(250);
        idle_on = 1'b0;
        random_run(180);
        drain();

        if (errors == 0 && outstanding == 0)
        begin
            $display("[pair_energy_9_6_accumulator_top] OK");
        end
        else
        begin
            $display("[pair_energy_9_6_accumulator_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
